[hdl/nfba_pkg.sv]
package nfba_pkg;

  localparam int WORD_W = 64;
  localparam int BIT_W = 6;
  localparam int IDX_W = 12;
  localparam int DEF_POOL_SIZE = 4096;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_WR,
    ST_DELIVER
  } alloc_state_t;

  typedef struct packed {
    logic found;
    logic [BIT_W-1:0] bit_pos;
  } ffz_t;

  // Finds the lowest clear bit of a bitmap word in two narrow steps:
  // first the lowest octet that holds a clear bit, then the bit inside it.
  function automatic ffz_t find_first_zero(input logic [WORD_W-1:0] word);
    logic [7:0] grp_free;
    logic [2:0] grp;
    logic [7:0] octet;
    logic [2:0] pos;
    ffz_t res;
    for (int i = 0; i < 8; i++) begin
      grp_free[i] = ~&word[i*8 +: 8];
    end
    grp = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (grp_free[i]) begin
        grp = 3'(i);
      end
    end
    octet = word[{grp, 3'b000} +: 8];
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!octet[i]) begin
        pos = 3'(i);
      end
    end
    res.found = |grp_free;
    res.bit_pos = {grp, pos};
    return res;
  endfunction

endpackage

[hdl/next_fit_block_allocator.sv]
// Next-fit block allocator over a pool of POOL_SIZE blocks, block 0 reserved.
// Request channel (req_valid / req_stall) carries func and block_index; an
// allocate returns the next free block found scanning forward from the last
// grant, wrapping around, and a free clears the given block and echoes it.
// Response channel (rsp_valid / rsp_stall) carries granted_index and status,
// where status reports a full pool on allocate.
// The used bitmap lives in a memory of 64-bit words with a registered read.
// One compare-and-encode unit examines one word per cycle, so an allocate
// covers at most one full pass of the bitmap, wrapping around, before its
// response; the start word is read twice, once for its upper and once for its
// lower part. A free clears its bit with one write unless it is ignored.
// One request is in progress at a time; req_stall is high until its response
// sits in the output register. A response held by rsp_stall keeps the next
// request from finishing, but that request is still accepted.
// After reset the block runs a clearing pass through the bitmap with
// req_stall high.
module next_fit_block_allocator #(
  parameter int POOL_SIZE = nfba_pkg::DEF_POOL_SIZE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       func,
  input  logic [nfba_pkg::IDX_W-1:0] block_index,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [nfba_pkg::IDX_W-1:0] granted_index,
  output logic                       status
);

  localparam int WORD_W = nfba_pkg::WORD_W;
  localparam int BIT_W = nfba_pkg::BIT_W;
  localparam int IDX_W = nfba_pkg::IDX_W;
  localparam int NUM_WORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int WA_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int POS_W = $clog2(POOL_SIZE);
  localparam int CNT_W = $clog2(NUM_WORDS + 1);
  localparam int EXT_W = WA_W + BIT_W;

  nfba_pkg::alloc_state_t state, state_next;

  logic [WORD_W-1:0] mem [NUM_WORDS];
  logic [WORD_W-1:0] rdata;

  logic              mem_re;
  logic [WA_W-1:0]   mem_raddr;
  logic              mem_we;
  logic [WA_W-1:0]   mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [WA_W-1:0]   clr_addr;
  logic [WA_W-1:0]   eval_addr;
  logic [CNT_W-1:0]  scan_cnt;
  logic [BIT_W-1:0]  start_bit;
  logic [POS_W-1:0]  search_start;
  logic [WA_W-1:0]   free_word;
  logic [BIT_W-1:0]  free_bit;
  logic [IDX_W-1:0]  res_index;
  logic              res_status;

  logic [EXT_W-1:0]  start_ext;
  logic [WA_W-1:0]   start_word;
  logic [WA_W-1:0]   eval_addr_next;
  logic              req_xfer;
  logic              rsp_free;
  logic              free_ok;
  logic              scan_last;
  logic [WORD_W-1:0] scan_word;
  logic [WORD_W-1:0] clr_word;
  nfba_pkg::ffz_t    ffz;
  logic [EXT_W-1:0]  hit_ext;

  assign req_xfer = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign start_ext = EXT_W'(search_start);
  assign start_word = start_ext[EXT_W-1:BIT_W];
  assign free_ok = (block_index != '0) && (32'(block_index) < 32'(POOL_SIZE));
  assign scan_last = (scan_cnt == CNT_W'(NUM_WORDS));
  assign eval_addr_next = (eval_addr == WA_W'(NUM_WORDS - 1)) ? '0 : eval_addr + 1'b1;

  // The start word is seen twice: first its bits at and above the start
  // position, on the final pass only the bits below it.
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      scan_word[j] = rdata[j]
                   | ((scan_cnt == '0) && (BIT_W'(j) < start_bit))
                   | (scan_last && (BIT_W'(j) >= start_bit));
    end
  end

  assign ffz = nfba_pkg::find_first_zero(scan_word);
  assign hit_ext = {eval_addr, ffz.bit_pos};

  // Bits past the end of the pool are stored as used, so the scan never
  // returns them and nothing else needs to mask them.
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      clr_word[j] = (32'({clr_addr, BIT_W'(j)}) == 32'd0)
                  || (32'({clr_addr, BIT_W'(j)}) >= 32'(POOL_SIZE));
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nfba_pkg::ST_CLEAR: begin
        if (clr_addr == WA_W'(NUM_WORDS - 1)) begin
          state_next = nfba_pkg::ST_IDLE;
        end
      end
      nfba_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (func == nfba_pkg::FUNC_ALLOC) begin
            state_next = nfba_pkg::ST_SCAN;
          end else if (free_ok) begin
            state_next = nfba_pkg::ST_FREE_WR;
          end else begin
            state_next = nfba_pkg::ST_DELIVER;
          end
        end
      end
      nfba_pkg::ST_SCAN: begin
        if (ffz.found || scan_last) begin
          state_next = nfba_pkg::ST_DELIVER;
        end
      end
      nfba_pkg::ST_FREE_WR: begin
        state_next = nfba_pkg::ST_DELIVER;
      end
      nfba_pkg::ST_DELIVER: begin
        if (rsp_free) begin
          state_next = nfba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nfba_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    req_stall = (state != nfba_pkg::ST_IDLE);
    mem_re = 1'b0;
    mem_raddr = eval_addr_next;
    mem_we = 1'b0;
    mem_waddr = eval_addr;
    mem_wdata = rdata | (WORD_W'(1) << ffz.bit_pos);
    unique case (state)
      nfba_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = clr_word;
      end
      nfba_pkg::ST_IDLE: begin
        mem_re = req_valid;
        mem_raddr = (func == nfba_pkg::FUNC_ALLOC) ? start_word
                                                   : WA_W'(block_index[IDX_W-1:BIT_W]);
      end
      nfba_pkg::ST_SCAN: begin
        mem_re = 1'b1;
        mem_we = ffz.found;
      end
      nfba_pkg::ST_FREE_WR: begin
        mem_we = 1'b1;
        mem_waddr = free_word;
        mem_wdata = rdata & ~(WORD_W'(1) << free_bit);
      end
      nfba_pkg::ST_DELIVER: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfba_pkg::ST_CLEAR;
      clr_addr <= '0;
      search_start <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == nfba_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == nfba_pkg::ST_SCAN && ffz.found) begin
        search_start <= hit_ext[POS_W-1:0];
      end
      if (state == nfba_pkg::ST_DELIVER && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      start_bit <= start_ext[BIT_W-1:0];
      eval_addr <= start_word;
      scan_cnt <= '0;
      free_word <= WA_W'(block_index[IDX_W-1:BIT_W]);
      free_bit <= block_index[BIT_W-1:0];
      res_index <= block_index;
      res_status <= nfba_pkg::STATUS_OK;
    end else if (state == nfba_pkg::ST_SCAN) begin
      if (ffz.found) begin
        res_index <= IDX_W'(hit_ext);
        res_status <= nfba_pkg::STATUS_OK;
      end else if (scan_last) begin
        res_index <= '0;
        res_status <= nfba_pkg::STATUS_FULL;
      end else begin
        eval_addr <= eval_addr_next;
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
    if (state == nfba_pkg::ST_DELIVER && rsp_free) begin
      granted_index <= res_index;
      status <= res_status;
    end
  end

  a_rsp_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == nfba_pkg::ST_DELIVER))
    else $error("response raised outside the deliver step");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == nfba_pkg::ST_SCAN) |-> (scan_cnt <= CNT_W'(NUM_WORDS)))
    else $error("scan ran past one full pass of the bitmap");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == nfba_pkg::STATUS_FULL) |-> (granted_index == '0))
    else $error("full response carries a nonzero index");

  a_start_range: assert property (@(posedge clk) disable iff (rst)
    32'(search_start) < 32'(POOL_SIZE))
    else $error("scan start outside the pool");

endmodule
